// ===== hdl/gdfw_pkg.sv =====
package gdfw_pkg;

    localparam int VERTEX_COUNT_DEFAULT = 4;
    localparam int VTX_FIELD_W          = 2;
    localparam int ADJ_MAX_BITS         = 64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } walk_state_t;

    typedef enum logic [2:0] {
        STK_HOLD,
        STK_INIT,
        STK_ADVANCE,
        STK_PUSH,
        STK_POP
    } stack_op_t;

    typedef struct packed {
        logic col_done;
        logic hit;
    } edge_result_t;

    // complete graph without self loops, row-major, n*n bits
    function automatic logic [ADJ_MAX_BITS-1:0] complete_graph(input int n);
        logic [ADJ_MAX_BITS-1:0] m;
        m = '0;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                if (r != c)
                begin
                    m[r*n+c] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

// ===== hdl/gdfw_edge_unit.sv =====
module gdfw_edge_unit
    import gdfw_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEFAULT,
    localparam int IW = $clog2(VERTEX_COUNT),
    localparam int CW = $clog2(VERTEX_COUNT + 1)
)
(
    input  logic [VERTEX_COUNT*VERTEX_COUNT-1:0] adjacency,
    input  logic [VERTEX_COUNT-1:0]              visited,
    input  logic [IW-1:0]                        vertex,
    input  logic [CW-1:0]                        col,
    output edge_result_t                         result
);

    logic [VERTEX_COUNT-1:0] row;
    logic [IW-1:0]           col_idx;

    assign row     = adjacency[vertex*VERTEX_COUNT +: VERTEX_COUNT];
    assign col_idx = col[IW-1:0];

    always_comb
    begin
        result.col_done = (col >= CW'(VERTEX_COUNT));
        // edge present and target not yet reached
        result.hit      = !result.col_done && row[col_idx] && !visited[col_idx];
    end

endmodule

// ===== hdl/gdfw_stack.sv =====
module gdfw_stack
    import gdfw_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEFAULT,
    localparam int IW = $clog2(VERTEX_COUNT),
    localparam int CW = $clog2(VERTEX_COUNT + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  stack_op_t     op,
    input  logic [IW-1:0] new_vertex,
    output logic [IW-1:0] top_vertex,
    output logic [CW-1:0] top_col,
    output logic [CW-1:0] depth
);

    logic [IW-1:0] vtx_reg [VERTEX_COUNT];
    logic [CW-1:0] col_reg [VERTEX_COUNT];
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] depth_next;
    logic [CW-1:0] top_wide;
    logic [IW-1:0] top_idx;
    logic [IW-1:0] push_idx;

    assign top_wide   = depth_reg - CW'(1);
    assign top_idx    = top_wide[IW-1:0];
    assign push_idx   = depth_reg[IW-1:0];
    assign top_vertex = vtx_reg[top_idx];
    assign top_col    = col_reg[top_idx];
    assign depth      = depth_reg;

    always_comb
    begin
        depth_next = depth_reg;
        unique case (op)
            STK_INIT: depth_next = CW'(1);
            STK_PUSH: depth_next = depth_reg + CW'(1);
            STK_POP:  depth_next = depth_reg - CW'(1);
            default:  depth_next = depth_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            STK_INIT:
            begin
                vtx_reg[0] <= new_vertex;
                col_reg[0] <= '0;
            end
            STK_ADVANCE:
            begin
                col_reg[top_idx] <= top_col + CW'(1);
            end
            STK_PUSH:
            begin
                // the current frame moves on and the new frame starts at column zero
                col_reg[top_idx]  <= top_col + CW'(1);
                vtx_reg[push_idx] <= new_vertex;
                col_reg[push_idx] <= '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/graph_depth_first_walk.sv =====
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    start_vertex
// out      from block out_valid / out_stall  visited_vertex, last_of_walk
// cfg      to block   cfg_wr_en              cfg_wr_data (adjacency matrix)
//
// a walk tests one adjacency bit per cycle in the shared edge unit, pushing or
// popping one stack frame in the same cycle; the results are then loaded one at
// a time into the output register, which holds while full and out_stall is high.
// in_stall stays high from the accepted start until the last result is loaded.
// a start at or above the vertex count is accepted but produces no result.
// reset clears control state and loads the complete graph into the matrix.
module graph_depth_first_walk
    import gdfw_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEFAULT,
    localparam int IW = $clog2(VERTEX_COUNT),
    localparam int CW = $clog2(VERTEX_COUNT + 1),
    localparam int AW = VERTEX_COUNT * VERTEX_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [AW-1:0]          cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VTX_FIELD_W-1:0] start_vertex,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VTX_FIELD_W-1:0] visited_vertex,
    output logic                   last_of_walk
);

    localparam logic [ADJ_MAX_BITS-1:0] ADJ_RESET_FULL = complete_graph(VERTEX_COUNT);
    localparam logic [AW-1:0]           ADJ_RESET      = ADJ_RESET_FULL[AW-1:0];

    walk_state_t             state_reg, state_next;
    logic [AW-1:0]           adj_reg;
    logic [VERTEX_COUNT-1:0] visited_reg, visited_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [IW-1:0]           emit_idx_reg, emit_idx_next;
    logic [IW-1:0]           order_reg [VERTEX_COUNT];
    logic                    order_we;
    logic [IW-1:0]           order_waddr;
    logic [IW-1:0]           order_wdata;
    logic                    out_valid_reg, out_valid_next;
    logic [VTX_FIELD_W-1:0]  out_vertex_reg;
    logic                    out_last_reg;
    logic                    out_load;

    stack_op_t               stk_op;
    logic [IW-1:0]           stk_new_vertex;
    logic [IW-1:0]           top_vertex;
    logic [CW-1:0]           top_col;
    logic [CW-1:0]           depth;
    edge_result_t            edge_res;

    logic                    in_xfer;
    logic                    start_ok;
    logic [IW+VTX_FIELD_W-1:0] start_ext;
    logic [IW-1:0]           start_v;
    logic [IW+VTX_FIELD_W-1:0] emit_ext;
    logic                    emit_last;
    logic [CW-1:0]           count_m1;

    gdfw_edge_unit #(.VERTEX_COUNT(VERTEX_COUNT)) u_edge (
        .adjacency (adj_reg),
        .visited   (visited_reg),
        .vertex    (top_vertex),
        .col       (top_col),
        .result    (edge_res)
    );

    gdfw_stack #(.VERTEX_COUNT(VERTEX_COUNT)) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (stk_op),
        .new_vertex (stk_new_vertex),
        .top_vertex (top_vertex),
        .top_col    (top_col),
        .depth      (depth)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign start_ok  = (int'(start_vertex) < VERTEX_COUNT);
    assign start_ext = {{IW{1'b0}}, start_vertex};
    assign start_v   = start_ext[IW-1:0];
    assign emit_ext  = {{VTX_FIELD_W{1'b0}}, order_reg[emit_idx_reg]};
    assign count_m1  = count_reg - CW'(1);
    assign emit_last = (CW'(emit_idx_reg) == count_m1);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign out_valid      = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign last_of_walk   = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        visited_next   = visited_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        order_we       = 1'b0;
        order_waddr    = count_reg[IW-1:0];
        order_wdata    = top_col[IW-1:0];
        stk_op         = STK_HOLD;
        stk_new_vertex = top_col[IW-1:0];
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && start_ok)
                begin
                    visited_next   = VERTEX_COUNT'(1) << start_v;
                    count_next     = CW'(1);
                    order_we       = 1'b1;
                    order_waddr    = '0;
                    order_wdata    = start_v;
                    stk_op         = STK_INIT;
                    stk_new_vertex = start_v;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (depth == '0)
                begin
                    emit_idx_next = '0;
                    state_next    = S_EMIT;
                end
                else if (edge_res.col_done)
                begin
                    stk_op = STK_POP;
                end
                else if (edge_res.hit)
                begin
                    visited_next = visited_reg | (VERTEX_COUNT'(1) << top_col[IW-1:0]);
                    count_next   = count_reg + CW'(1);
                    order_we     = 1'b1;
                    stk_op       = STK_PUSH;
                end
                else
                begin
                    stk_op = STK_ADVANCE;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    emit_idx_next  = emit_idx_reg + IW'(1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            adj_reg       <= ADJ_RESET;
            visited_reg   <= '0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                adj_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_reg[order_waddr] <= order_wdata;
        end
        if (out_load)
        begin
            out_vertex_reg <= emit_ext[VTX_FIELD_W-1:0];
            out_last_reg   <= emit_last;
        end
    end

`ifndef NO_ASSERTIONS
    // the visited bitmap holds as many vertices as the order buffer holds results
    a_count_matches_visited: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(visited_reg) == int'(count_reg))
        else $error("visited bitmap and result count disagree");

    // a finished walk leaves the stack empty
    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (depth == '0))
        else $error("stack not empty while idle");

    // an active walk always holds between one and N results
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg != '0 && int'(count_reg) <= VERTEX_COUNT))
        else $error("result count out of range during a walk");

    // the stack never grows past the vertex count
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(depth) <= VERTEX_COUNT)
        else $error("stack depth beyond vertex count");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import gdfw_pkg::*;
();

    localparam int NV = 4;
    localparam int AW = NV * NV;
    localparam int LONG_HOLD = 300;
    localparam int END_WAIT = 40;
    localparam logic [AW-1:0] ADJ_COMPLETE = 16'h7BDE;

    typedef struct packed {
        logic [VTX_FIELD_W-1:0] vertex;
        logic                   last;
    } visit_t;

    class walk_scoreboard;
        logic [AW-1:0] matrix;
        visit_t        preorder_q[$];
        int            errors;

        function new();
            matrix = ADJ_COMPLETE;
            errors = 0;
        endfunction

        // depth-first preorder from start, neighbours tried in ascending order
        function void note_start(logic [VTX_FIELD_W-1:0] start);
            logic [NV-1:0] seen;
            int frame_v[NV];
            int frame_c[NV];
            int depth;
            int v;
            int c;
            int order[$];
            visit_t item;
            if (int'(start) >= NV)
            begin
                return;
            end
            seen = '0;
            seen[start] = 1'b1;
            order.push_back(int'(start));
            frame_v[0] = int'(start);
            frame_c[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                v = frame_v[depth-1];
                c = frame_c[depth-1];
                if (c >= NV)
                begin
                    depth--;
                end
                else
                begin
                    frame_c[depth-1] = c + 1;
                    if (matrix[v*NV+c] && !seen[c])
                    begin
                        seen[c] = 1'b1;
                        if (order.size() < NV)
                        begin
                            order.push_back(c);
                        end
                        if (depth < NV)
                        begin
                            frame_v[depth] = c;
                            frame_c[depth] = 0;
                            depth++;
                        end
                    end
                end
            end
            foreach (order[k])
            begin
                item.vertex = order[k][VTX_FIELD_W-1:0];
                item.last = (k == order.size() - 1);
                preorder_q.push_back(item);
            end
        endfunction

        function void check_visit(logic [VTX_FIELD_W-1:0] vertex, logic last);
            visit_t want;
            if (preorder_q.size() == 0)
            begin
                $error("unexpected result: visited_vertex %0d last_of_walk %0b", vertex, last);
                errors++;
                return;
            end
            want = preorder_q.pop_front();
            if (vertex !== want.vertex)
            begin
                $error("visited_vertex: expected %0d, actual %0d", want.vertex, vertex);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_walk: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [AW-1:0]          cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [VTX_FIELD_W-1:0] start_vertex;
    logic                   out_valid;
    logic                   out_stall;
    logic [VTX_FIELD_W-1:0] visited_vertex;
    logic                   last_of_walk;

    bit long_hold_req;

    walk_scoreboard sb = new();

    graph_depth_first_walk #(
        .VERTEX_COUNT(NV)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_vertex  (start_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .visited_vertex(visited_vertex),
        .last_of_walk  (last_of_walk)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_visit(visited_vertex, last_of_walk);
        end
    end

    // receiver: free runs, random stall runs, and a long hold on request
    initial
    begin
        int mode;
        int len;
        out_stall <= 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len = $urandom_range(4, 40);
                repeat (len)
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // returns in the time step of the edge that took the transfer
    task automatic offer_start(input logic [VTX_FIELD_W-1:0] v);
        in_valid <= 1'b1;
        start_vertex <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_start(v);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        start_vertex <= VTX_FIELD_W'($urandom_range(0, NV - 1));
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.preorder_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_matrix(input logic [AW-1:0] m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.matrix = m;
    endtask

    task automatic random_phase(input int count, input bit hold);
        int sent;
        int burst;
        bit no_gaps;
        no_gaps = ($urandom_range(0, 3) == 0);
        sent = 0;
        if (hold)
        begin
            // block fills up behind a stalled output
            long_hold_req = 1'b1;
        end
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    offer_start(VTX_FIELD_W'($urandom_range(0, NV - 1)));
                    sent++;
                end
            end
            if (!no_gaps && sent < count && $urandom_range(0, 2) != 0)
            begin
                pause_sender($urandom_range(1, 12));
            end
        end
        drain_results();
    endtask

    function automatic logic [AW-1:0] random_matrix();
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        a = AW'($urandom());
        b = AW'($urandom());
        case ($urandom_range(0, 5))
            0: return a & b;
            1: return a & b & AW'($urandom());
            2: return a | b;
            3: return ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: return a;
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        start_vertex <= '0;
        long_hold_req = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // complete graph out of reset
        offer_start(2'd0);
        offer_start(2'd1);
        offer_start(2'd2);
        offer_start(2'd3);
        drain_results();
        // no edges: each walk is just its start
        write_matrix('0);
        offer_start(2'd0);
        offer_start(2'd3);
        drain_results();
        // every bit set, self loops included
        write_matrix('1);
        offer_start(2'd1);
        offer_start(2'd2);
        drain_results();
        // self loops on all vertices plus 2 -> 0
        write_matrix(16'h8521);
        offer_start(2'd2);
        offer_start(2'd1);
        drain_results();
        // chain 3 -> 2 -> 1 -> 0
        write_matrix(16'h4210);
        offer_start(2'd3);
        offer_start(2'd0);
        drain_results();
        // 0 -> 1 -> 2, then back up to 0 -> 3
        write_matrix(16'h004A);
        offer_start(2'd0);
        offer_start(2'd1);
        drain_results();

        for (int p = 0; p < 8; p++)
        begin
            write_matrix(random_matrix());
            random_phase($urandom_range(10, 16), p == 3);
        end

        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.preorder_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
